// ===== design/lcr_pkg.sv =====
// ----------------------------------------------------------------------------
// lcr_pkg: shared types and constants for the largest region size core
// Holds the controller/datapath command and status structs and defaults.
// ----------------------------------------------------------------------------
package lcr_pkg;

  localparam int DEF_MAX_WIDTH  = 128;
  localparam int DEF_MAX_HEIGHT = 128;
  localparam int DIM_W          = 8;
  localparam int CNT_W          = 15;
  localparam logic [CNT_W-1:0] CNT_SAT = {CNT_W{1'b1}};
  localparam logic [DIM_W-1:0] DIM_RESET = 8'd128;

  // Register indexes, taken from paddr[2].
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  typedef struct packed {
    logic load_en;
    logic scan_init;
    logic scan_rd;
    logic scan_start;
    logic scan_next;
    logic pop_rd;
    logic nbr_issue;
    logic best_upd;
    logic res_load;
  } lcr_cmd_t;

  typedef struct packed {
    logic load_last;
    logic scan_hit;
    logic scan_last;
    logic stack_empty;
    logic nbr_last;
    logic out_free;
  } lcr_status_t;

  typedef struct packed {
    logic up;
    logic down;
    logic left;
    logic right;
  } lcr_dir_t;

  // Neighbor directions in visiting order.
  function automatic lcr_dir_t nbr_dir(input logic [2:0] k);
    lcr_dir_t d;
    d = '0;
    case (k)
      3'd0: begin d.up = 1'b1;   d.left = 1'b1;  end
      3'd1: begin d.up = 1'b1;                   end
      3'd2: begin d.up = 1'b1;   d.right = 1'b1; end
      3'd3: begin d.left = 1'b1;                 end
      3'd4: begin d.right = 1'b1;                end
      3'd5: begin d.down = 1'b1; d.left = 1'b1;  end
      3'd6: begin d.down = 1'b1;                 end
      default: begin d.down = 1'b1; d.right = 1'b1; end
    endcase
    return d;
  endfunction

endpackage

// ===== design/largest_connected_region_size_core.sv =====
// ----------------------------------------------------------------------------
// largest_connected_region_size_core: largest 8-connected region of a frame
// Loads a binary frame in raster order and reports its largest region size.
// ----------------------------------------------------------------------------
// Cells stream in one per request at one cell a cycle while a frame is being
// loaded. After the last cell of a frame (frame_width by frame_height, each
// clamped to 1..MAX) the block walks the stored frame with a depth-first flood
// fill and returns one request carrying the size of the largest 8-connected
// region of true cells, saturating at 32767. The fill is bounded by the single
// read port of the cell memory: every scanned cell is read, then checked, and
// every true cell takes a stack pop, eight neighbor reads and a drain step,
// plus one closing step per region, before the result appears.
// No input is taken during the fill; the next frame may load while a finished
// result still waits on the output. A configuration write restarts the frame
// being loaded. No clearing pass is needed after reset: loading a cell also
// clears its visited mark.
// ----------------------------------------------------------------------------
module largest_connected_region_size_core #(
  parameter int MAX_WIDTH  = lcr_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = lcr_pkg::DEF_MAX_HEIGHT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // [0] cell_value, [7:1] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,    // [14:0] largest_region_size, [15] zero
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import lcr_pkg::*;

  logic [DIM_W-1:0] frame_width_r, frame_height_r;
  logic             cfg_wr;
  logic             in_ready;
  logic             in_fire;
  lcr_cmd_t         cmd;
  lcr_status_t      sts;
  logic [CNT_W-1:0] out_size;

  // Register writes complete in the access phase; pready is tied high.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= DIM_RESET;
      frame_height_r <= DIM_RESET;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_FRAME_WIDTH) frame_width_r  <= cfg_pwdata[DIM_W-1:0];
      else                                 frame_height_r <= cfg_pwdata[DIM_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_FRAME_WIDTH) ? 32'(frame_width_r)
                                                        : 32'(frame_height_r);

  assign in_tready = in_ready;
  assign in_fire   = in_tvalid && in_ready;

  lcr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .sts      (sts),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  lcr_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .cfg_wr       (cfg_wr),
    .cell_value   (in_tdata[0]),
    .cmd          (cmd),
    .sts          (sts),
    .out_ready    (out_tready),
    .out_valid    (out_tvalid),
    .out_size     (out_size)
  );

  assign out_tdata = {1'b0, out_size};

endmodule

// ===== design/lcr_ctrl.sv =====
// ----------------------------------------------------------------------------
// lcr_ctrl: sequencing state machine
// Steps through frame load, start-cell scan, flood fill and result hand-off.
// ----------------------------------------------------------------------------
module lcr_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_fire,
  input  lcr_pkg::lcr_status_t sts,
  output logic               in_ready,
  output lcr_pkg::lcr_cmd_t  cmd
);
  import lcr_pkg::*;

  typedef enum logic [6:0] {
    ST_LOAD    = 7'b0000001,
    ST_SCAN_RD = 7'b0000010,
    ST_SCAN_CK = 7'b0000100,
    ST_POP     = 7'b0001000,
    ST_NBR     = 7'b0010000,
    ST_DRAIN   = 7'b0100000,
    ST_FINISH  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_LOAD;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_fire) begin
          cmd.load_en = 1'b1;
          if (sts.load_last) begin
            cmd.scan_init = 1'b1;
            state_nxt     = ST_SCAN_RD;
          end
        end
      end
      ST_SCAN_RD: begin
        cmd.scan_rd = 1'b1;
        state_nxt   = ST_SCAN_CK;
      end
      ST_SCAN_CK: begin
        if (sts.scan_hit) begin
          cmd.scan_start = 1'b1;
          state_nxt      = ST_POP;
        end else if (sts.scan_last) begin
          state_nxt = ST_FINISH;
        end else begin
          cmd.scan_next = 1'b1;
          state_nxt     = ST_SCAN_RD;
        end
      end
      ST_POP: begin
        if (sts.stack_empty) begin
          cmd.best_upd = 1'b1;
          if (sts.scan_last) begin
            state_nxt = ST_FINISH;
          end else begin
            cmd.scan_next = 1'b1;
            state_nxt     = ST_SCAN_RD;
          end
        end else begin
          cmd.pop_rd = 1'b1;
          state_nxt  = ST_NBR;
        end
      end
      ST_NBR: begin
        cmd.nbr_issue = 1'b1;
        if (sts.nbr_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_nxt = ST_POP;
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  // A new frame is only taken while the controller is loading.
  a_load_only: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_en |-> state_r == ST_LOAD)
    else $error("cell written outside load phase");
  // Every fill step is followed by its drain state before the next pop.
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_NBR && sts.nbr_last) |=> state_r == ST_DRAIN)
    else $error("neighbor pass not drained");
  // A result is only loaded when the output slot can take it.
  a_res: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_load |-> sts.out_free)
    else $error("result overwrote a pending result");

endmodule

// ===== design/lcr_datapath.sv =====
// ----------------------------------------------------------------------------
// lcr_datapath: cell memory, fill stack, counters and result register
// Executes the controller's commands and reports status back.
// ----------------------------------------------------------------------------
module lcr_datapath #(
  parameter int MAX_WIDTH  = lcr_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = lcr_pkg::DEF_MAX_HEIGHT
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [lcr_pkg::DIM_W-1:0]   frame_width,
  input  logic [lcr_pkg::DIM_W-1:0]   frame_height,
  input  logic                        cfg_wr,
  input  logic                        cell_value,
  input  lcr_pkg::lcr_cmd_t           cmd,
  output lcr_pkg::lcr_status_t        sts,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [lcr_pkg::CNT_W-1:0]   out_size
);
  import lcr_pkg::*;

  localparam int CW        = $clog2(MAX_WIDTH);
  localparam int RW        = $clog2(MAX_HEIGHT);
  localparam int AW        = RW + CW;
  localparam int MEM_DEPTH = MAX_HEIGHT * (2 ** CW);
  localparam int STK_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int SPW       = $clog2(STK_DEPTH + 1);
  localparam int SIW       = $clog2(STK_DEPTH);
  localparam int XW        = (CW + 1 > DIM_W) ? CW + 1 : DIM_W;

  // Effective dimensions, clamped to 1..MAX.
  logic [XW-1:0] fw_x, fh_x, wlim, hlim, wm1_x, hm1_x;
  logic [CW-1:0] wm1;
  logic [RW-1:0] hm1;

  always_comb begin
    fw_x = XW'(frame_width);
    fh_x = XW'(frame_height);
    if (fw_x == '0)                  wlim = XW'(1);
    else if (fw_x > XW'(MAX_WIDTH))  wlim = XW'(MAX_WIDTH);
    else                             wlim = fw_x;
    if (fh_x == '0)                  hlim = XW'(1);
    else if (fh_x > XW'(MAX_HEIGHT)) hlim = XW'(MAX_HEIGHT);
    else                             hlim = fh_x;
    wm1_x = wlim - XW'(1);
    hm1_x = hlim - XW'(1);
    wm1   = wm1_x[CW-1:0];
    hm1   = hm1_x[RW-1:0];
  end

  // Cell memory: bit 0 is the cell, bit 1 the visited mark. Loading a cell
  // clears its mark, so every frame starts with a clean visited map.
  logic [1:0]    mem [0:MEM_DEPTH-1];
  logic [1:0]    rdata_r;
  logic [AW-1:0] stk [0:STK_DEPTH-1];
  logic [AW-1:0] stk_q_r;

  logic [RW-1:0] lrow_r, srow_r;
  logic [CW-1:0] lcol_r, scol_r;
  logic [SPW-1:0] sp_r;
  logic [2:0]    k_r;
  logic          chk_v_r;
  logic [AW-1:0] chk_addr_r;
  logic [CNT_W-1:0] cnt_r, best_r;
  logic          out_valid_r;
  logic [CNT_W-1:0] out_size_r;

  logic [RW-1:0] cur_row, nrow;
  logic [CW-1:0] cur_col, ncol;
  lcr_dir_t      dir;
  logic          n_in;
  logic          chk_hit;
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [1:0]    mem_wdata;
  logic          push;
  logic [AW-1:0] push_data;
  logic          rd_en;
  logic [SPW-1:0] sp_m1;

  assign cur_row = stk_q_r[AW-1:CW];
  assign cur_col = stk_q_r[CW-1:0];
  assign sp_m1   = sp_r - SPW'(1);

  always_comb begin
    dir  = nbr_dir(k_r);
    nrow = dir.up ? cur_row - RW'(1) : (dir.down ? cur_row + RW'(1) : cur_row);
    ncol = dir.left ? cur_col - CW'(1) : (dir.right ? cur_col + CW'(1) : cur_col);
    n_in = !(dir.up && cur_row == '0) && !(dir.down && cur_row == hm1) &&
           !(dir.left && cur_col == '0) && !(dir.right && cur_col == wm1);
  end

  assign chk_hit = chk_v_r && rdata_r[0] && !rdata_r[1];

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = chk_addr_r;
    mem_wdata = 2'b11;
    push      = 1'b0;
    push_data = chk_addr_r;
    if (cmd.load_en) begin
      mem_we    = 1'b1;
      mem_waddr = {lrow_r, lcol_r};
      mem_wdata = {1'b0, cell_value};
    end else if (cmd.scan_start) begin
      mem_we    = 1'b1;
      mem_waddr = {srow_r, scol_r};
      push      = 1'b1;
      push_data = {srow_r, scol_r};
    end else if (chk_hit) begin
      mem_we = 1'b1;
      push   = 1'b1;
    end
    rd_en     = cmd.scan_rd || cmd.nbr_issue;
    mem_raddr = cmd.scan_rd ? {srow_r, scol_r} : {nrow, ncol};
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (rd_en)  rdata_r <= mem[mem_raddr];
    if (push)   stk[sp_r[SIW-1:0]] <= push_data;
    if (cmd.pop_rd) stk_q_r <= stk[sp_m1[SIW-1:0]];
    chk_addr_r <= {nrow, ncol};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lrow_r      <= '0;
      lcol_r      <= '0;
      srow_r      <= '0;
      scol_r      <= '0;
      sp_r        <= '0;
      k_r         <= '0;
      chk_v_r     <= 1'b0;
      cnt_r       <= '0;
      best_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      chk_v_r <= cmd.nbr_issue && n_in;
      if (cfg_wr) begin
        lrow_r <= '0;
        lcol_r <= '0;
      end else if (cmd.load_en) begin
        if (lcol_r == wm1) begin
          lcol_r <= '0;
          lrow_r <= (lrow_r == hm1) ? '0 : lrow_r + RW'(1);
        end else begin
          lcol_r <= lcol_r + CW'(1);
        end
      end
      if (cmd.scan_init) begin
        srow_r <= '0;
        scol_r <= '0;
        best_r <= '0;
      end else if (cmd.scan_next) begin
        if (scol_r == wm1) begin
          scol_r <= '0;
          srow_r <= srow_r + RW'(1);
        end else begin
          scol_r <= scol_r + CW'(1);
        end
      end
      if (push)            sp_r <= sp_r + SPW'(1);
      else if (cmd.pop_rd) sp_r <= sp_m1;
      if (cmd.pop_rd)         k_r <= '0;
      else if (cmd.nbr_issue) k_r <= k_r + 3'd1;
      if (cmd.scan_start) cnt_r <= '0;
      else if (cmd.pop_rd && cnt_r != CNT_SAT) cnt_r <= cnt_r + CNT_W'(1);
      if (cmd.best_upd && cnt_r > best_r) best_r <= cnt_r;
      if (cmd.res_load)  out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) out_size_r <= best_r;
  end

  assign out_valid = out_valid_r;
  assign out_size  = out_size_r;

  always_comb begin
    sts.load_last   = (lrow_r == hm1) && (lcol_r == wm1);
    sts.scan_hit    = rdata_r[0] && !rdata_r[1];
    sts.scan_last   = (srow_r == hm1) && (scol_r == wm1);
    sts.stack_empty = (sp_r == '0);
    sts.nbr_last    = (k_r == 3'd7);
    sts.out_free    = !out_valid_r || out_ready;
  end

  a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SPW'(STK_DEPTH))
    else $error("fill stack overflow");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop_rd |-> (sp_r != '0) && !push)
    else $error("pop from empty stack or during push");
  a_wr_excl: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_en |-> !cmd.scan_start && !chk_v_r)
    else $error("mark write collides with cell load");

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for largest_connected_region_size_core
// Streams binary frames through the core and checks each reported region size
// against a flood-fill predictor kept inside the bench.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lcr_pkg::*;

  localparam int MAXW        = 128;
  localparam int MAXH        = 128;
  localparam int CELLS       = MAXW * MAXH;
  localparam int STALL_LIMIT = 200000;
  localparam int ITEM_GOAL   = 1550;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;    // [0] cell_value, [7:1] zero
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;        // [14:0] largest_region_size, [15] zero
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  largest_connected_region_size_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #5 clk = ~clk;

  // Bench copy of the core's state: raw register values, the frame being
  // loaded and the position of the next cell.
  logic [7:0]        width_reg = DIM_RESET;
  logic [7:0]        height_reg = DIM_RESET;
  bit                frame_cells [CELLS];
  int                load_pos = 0;
  logic [CNT_W-1:0]  expected_sizes [$];

  int sent_cells = 0;
  int failures = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int quiet_cycles = 0;

  // A register value of zero acts as one, anything above the maximum as the
  // maximum.
  function automatic int clamp_dim(logic [7:0] v, int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  // Depth-first flood fill over the stored frame, 8-connected.
  function automatic int largest_region(int w, int h);
    bit visited [CELLS];
    int stack [$];
    int best;
    int count;
    int cur;
    int r;
    int c;
    int nr;
    int nc;
    int nidx;
    best = 0;
    for (int s = 0; s < w * h; s++) begin
      if (!frame_cells[s] || visited[s]) continue;
      visited[s] = 1'b1;
      stack.push_back(s);
      count = 0;
      while (stack.size() != 0) begin
        cur = stack.pop_back();
        count++;
        r = cur / w;
        c = cur % w;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            nr = r + dr;
            nc = c + dc;
            if ((dr == 0 && dc == 0) || nr < 0 || nc < 0 || nr >= h || nc >= w) continue;
            nidx = nr * w + nc;
            if (frame_cells[nidx] && !visited[nidx]) begin
              visited[nidx] = 1'b1;
              stack.push_back(nidx);
            end
          end
        end
      end
      if (count > best) best = count;
    end
    if (best > 32767) best = 32767;
    return best;
  endfunction

  // Every accepted cell goes into the frame; the last cell of a frame yields
  // one expected region size.
  always @(posedge clk) begin
    int w;
    int h;
    if (rst_n && in_tvalid && in_tready) begin
      w = clamp_dim(width_reg, MAXW);
      h = clamp_dim(height_reg, MAXH);
      if (load_pos >= w * h) load_pos = 0;
      frame_cells[load_pos] = in_tdata[0];
      load_pos++;
      if (load_pos >= w * h) begin
        load_pos = 0;
        expected_sizes.push_back(CNT_W'(largest_region(w, h)));
      end
    end
  end

  // Result checker: each accepted result is matched against the oldest
  // expected size.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_sizes.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0d", $time,
                 out_tdata[14:0]);
        failures++;
      end else begin
        if (out_tdata[14:0] !== expected_sizes[0]) begin
          $display("%0t: region size mismatch, expected %0d, actual %0d", $time,
                   expected_sizes[0], out_tdata[14:0]);
          failures++;
        end
        void'(expected_sizes.pop_front());
      end
    end
  end

  // Receiver: stalls at random at the current rate.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog on cycles without any accepted request.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Sends one cell. Valid stays high afterwards so that back-to-back requests
  // carry no bubble; an idle gap lowers it in a step of its own. Ready is
  // sampled in the middle of the cycle, so the loop ends exactly at the edge
  // that accepts the cell.
  task automatic send_cell(bit value);
    bit ready_seen;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'b0, value};
    do begin
      @(negedge clk);
      ready_seen = in_tready;
      @(posedge clk);
    end while (!ready_seen);
    sent_cells++;
  endtask

  task automatic stop_sending();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // Holds off until every expected result has come back, plus a margin.
  task automatic wait_drained();
    stop_sending();
    while (expected_sizes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Register write: setup cycle, then access cycle; the write lands at the
  // edge that closes the access cycle.
  task automatic write_reg(logic reg_index, logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {reg_index, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (reg_index == REG_FRAME_WIDTH) width_reg = value[7:0];
    else height_reg = value[7:0];
    load_pos = 0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic set_frame(logic [31:0] w, logic [31:0] h);
    wait_drained();
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    @(posedge clk);
  endtask

  // Sends one whole frame with the given percentage of true cells.
  task automatic send_frame(int density);
    int n;
    n = clamp_dim(width_reg, MAXW) * clamp_dim(height_reg, MAXH);
    for (int i = 0; i < n; i++) send_cell($urandom_range(99) < density);
  endtask

  // Small hand-built frames: single cells, a diagonal chain, an empty frame and
  // a frame with three separate regions of two different sizes.
  task automatic test_directed();
    bit diag [9] = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
    bit split [9] = '{1, 1, 0, 0, 0, 0, 1, 0, 1};
    set_frame(32'd1, 32'd1);
    send_cell(1'b0);
    send_cell(1'b1);
    set_frame(32'd3, 32'd3);
    foreach (diag[i]) send_cell(diag[i]);
    // Sender holds off here until the result has come.
    wait_drained();
    foreach (split[i]) send_cell(split[i]);
    set_frame(32'd2, 32'd2);
    repeat (4) send_cell(1'b0);
  endtask

  // A register write in the middle of a frame drops the cells already sent.
  task automatic test_restart();
    set_frame(32'd4, 32'd1);
    repeat (3) send_cell(1'b1);
    stop_sending();
    write_reg(REG_FRAME_HEIGHT, 32'd1);
    @(posedge clk);
    send_cell(1'b0);
    send_cell(1'b1);
    send_cell(1'b0);
    send_cell(1'b1);
  endtask

  // Random frames, mostly small, some at the size extremes. Some dimension writes
  // carry random upper bits, which the core must ignore.
  task automatic test_random(int goal);
    int pick;
    logic [31:0] w;
    logic [31:0] h;
    while (sent_cells < goal) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        w = $urandom_range(12, 1);
        h = $urandom_range(12, 1);
        if ($urandom_range(3) == 0) begin
          w[31:8] = $urandom;
          h[31:8] = $urandom;
        end
        set_frame(w, h);
      end else if (pick < 66) begin
        case ($urandom_range(3))
          0: set_frame(32'd128, 32'd1);
          1: set_frame(32'd1, 32'd128);
          2: set_frame(32'd0, 32'hFFFF_FF00 | 32'd255);
          default: set_frame(32'd255, 32'd0);
        endcase
      end
      // Otherwise keep the dimensions and send frames back to back.
      send_frame($urandom_range(3) == 0 ? $urandom_range(100) : $urandom_range(70, 20));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 27;
    recv_idle_pct = 54;
    test_directed();
    test_restart();
    test_random(ITEM_GOAL / 3);

    send_idle_pct = 54;
    recv_idle_pct = 27;
    test_random(2 * ITEM_GOAL / 3);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(ITEM_GOAL);

    wait_drained();
    repeat (50) @(posedge clk);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
